FILE: hdl/catmull_rom_point_eval_core_assert.svh
// Assertion shorthands for the point evaluator checker.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef CATMULL_ROM_POINT_EVAL_CORE_ASSERT_SVH
`define CATMULL_ROM_POINT_EVAL_CORE_ASSERT_SVH

// Implication from one condition to a later or same-cycle consequence.
`define CRPE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that holds at every sampled edge outside reset.
`define CRPE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

FILE: hdl/crpe_pkg.sv
package crpe_pkg;

  // Field widths
  localparam int COORD_W = 32;
  localparam int CNT_W   = 7;
  localparam int PIDX_W  = 6;
  localparam int SEG_W   = 7;
  localparam int FRAC_W  = 17;

  // Table size and address width
  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);

  // Fraction scale: t = fraction / 2^T_LOG
  localparam int T_LOG = 16;
  localparam int T_ONE = 1 << T_LOG;

  // Rounding shifts of the weights (to Q30) and of the accumulator
  localparam int W_SHIFT   = 19;
  localparam int ACC_SHIFT = 30;

  // Cycles from the accepting edge to the edge that takes the result
  localparam int PIPE_LAT = 7;

  // Action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COORD_W-1:0] weight_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef point_t [3:0] point4_t;
  typedef logic [3:0][COORD_W-1:0] coord4_t;
  typedef logic [3:0][COORD_W-1:0] weight4_t;

  typedef struct packed {
    logic              action;
    logic [PIDX_W-1:0] point_index;
    coord_t            point_x;
    coord_t            point_y;
    logic [SEG_W-1:0]  segment;
    logic [FRAC_W-1:0] fraction;
  } in_item_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    logic   in_range;
  } out_item_t;

  // Table access request from the front end to the fetch unit
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    point_t            wr_pt;
    logic [SEG_W-1:0]  seg;
    logic [CNT_W-1:0]  cnt;
  } fetch_req_t;

endpackage

FILE: hdl/catmull_rom_point_eval_core.sv
// Catmull-Rom point evaluator: a start transaction is taken in every cycle (busy stays low).
// An evaluate transaction raises out_valid when its result leaves the pipeline, and the result is
// taken while out_valid is high; a write gives no result and reaches the table at once.
// Throughput: one transaction per cycle, set by the seven-stage evaluation pipeline.
// Reset (rst_n low, synchronous) sets point_count to 1 and empties the pipeline;
// table contents are kept. Results cannot be held off by the receiver.
module catmull_rom_point_eval_core
  import crpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0]    point_count_r;
  logic [CNT_W-1:0]    point_count_nxt;
  logic [CNT_W-1:0]    cnt_eff;
  logic                acc_go;
  logic                acc_eval;
  logic                in_rng;
  logic [PIPE_LAT-1:0] vld_r;
  logic [PIPE_LAT-1:0] vld_nxt;
  logic [PIPE_LAT-1:0] rng_r;
  logic [PIPE_LAT-1:0] rng_nxt;
  fetch_req_t          req;
  point4_t             pts;
  weight4_t            wts;
  coord4_t             xs;
  coord4_t             ys;
  coord_t              x_res;
  coord_t              y_res;

  assign busy     = 1'b0;
  assign acc_go   = start && !busy;
  assign acc_eval = acc_go && (in_item.action == ACT_EVAL);

  // Limit the point count to the table size
  assign cnt_eff = (point_count_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count_r;
  assign in_rng  = in_item.segment < cnt_eff;

  // Hold the point count between configuration writes
  assign point_count_nxt = cfg_we ? cfg_wdata : point_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= CNT_W'(1);
    end else begin
      point_count_r <= point_count_nxt;
    end
  end

  // Advance valid and range flags with the data
  assign vld_nxt = {vld_r[PIPE_LAT-2:0], acc_eval};
  assign rng_nxt = {rng_r[PIPE_LAT-2:0], acc_eval && in_rng};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rng_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      rng_r <= rng_nxt;
    end
  end

  // Table write and neighbor fetch
  always_comb begin
    req.wr_en    = acc_go && (in_item.action == ACT_WRITE);
    req.wr_addr  = in_item.point_index[ADDR_W-1:0];
    req.wr_pt.x  = in_item.point_x;
    req.wr_pt.y  = in_item.point_y;
    req.seg      = in_item.segment;
    req.cnt      = cnt_eff;
  end

  crpe_fetch u_fetch (
    .clk(clk),
    .req(req),
    .pts(pts)
  );

  crpe_weights u_weights (
    .clk (clk),
    .frac(in_item.fraction),
    .wts (wts)
  );

  // Split the points into per-axis lanes
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      xs[k] = pts[k].x;
      ys[k] = pts[k].y;
    end
  end

  crpe_blend u_blend_x (
    .clk(clk),
    .pts(xs),
    .wts(wts),
    .res(x_res)
  );

  crpe_blend u_blend_y (
    .clk(clk),
    .pts(ys),
    .wts(wts),
    .res(y_res)
  );

  // Drive zeros for a segment outside the points in use
  assign out_valid         = vld_r[PIPE_LAT-1];
  assign out_item.in_range = rng_r[PIPE_LAT-1];
  assign out_item.out_x    = rng_r[PIPE_LAT-1] ? x_res : '0;
  assign out_item.out_y    = rng_r[PIPE_LAT-1] ? y_res : '0;

endmodule

FILE: hdl/crpe_ram.sv
module crpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

FILE: hdl/crpe_fetch.sv
module crpe_fetch
  import crpe_pkg::*;
(
  input  logic       clk,
  input  fetch_req_t req,
  output point4_t    pts
);

  localparam logic [SEG_W:0]    MAX_IDX   = (SEG_W + 1)'(MAX_POINTS);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(MAX_POINTS - 1);

  logic [SEG_W:0]    seg_w;
  logic [SEG_W:0]    seg_p1;
  logic [SEG_W:0]    seg_p2;
  logic [SEG_W:0]    cnt_w;
  logic [SEG_W:0]    last_w;
  logic [SEG_W:0]    idx [4];
  logic [ADDR_W-1:0] raddr [4];
  point4_t           rd_pts;
  point4_t           pd1_r;
  point4_t           pd2_r;
  point4_t           pd3_r;

  function automatic logic [ADDR_W-1:0] clamp_addr(input logic [SEG_W:0] i);
    clamp_addr = (i >= MAX_IDX) ? LAST_SLOT : i[ADDR_W-1:0];
  endfunction

  // Neighbor indices, clamped to the first and last points in use
  always_comb begin
    seg_w  = {1'b0, req.seg};
    cnt_w  = (SEG_W + 1)'(req.cnt);
    seg_p1 = seg_w + (SEG_W + 1)'(1);
    seg_p2 = seg_w + (SEG_W + 1)'(2);
    last_w = cnt_w - (SEG_W + 1)'(1);
    idx[0] = (seg_w != '0) ? seg_w - (SEG_W + 1)'(1) : '0;
    idx[1] = seg_w;
    idx[2] = (seg_p1 < cnt_w) ? seg_p1 : last_w;
    idx[3] = (seg_p2 < cnt_w) ? seg_p2 : last_w;
    for (int k = 0; k < 4; k++) begin
      raddr[k] = clamp_addr(idx[k]);
    end
  end

  // One table copy per neighbor, all written together
  for (genvar g = 0; g < 4; g++) begin : g_tab
    crpe_ram #(
      .WIDTH($bits(point_t)),
      .DEPTH(MAX_POINTS)
    ) u_ram (
      .clk    (clk),
      .we     (req.wr_en),
      .waddr  (req.wr_addr),
      .wdata  (req.wr_pt),
      .raddr  (raddr[g]),
      .rdata_r(rd_pts[g])
    );
  end

  // Delay the points to line up with the weights
  always_ff @(posedge clk) begin
    pd1_r <= rd_pts;
    pd2_r <= pd1_r;
    pd3_r <= pd2_r;
  end

  assign pts = pd3_r;

endmodule

FILE: hdl/crpe_weights.sv
module crpe_weights
  import crpe_pkg::*;
(
  input  logic              clk,
  input  logic [FRAC_W-1:0] frac,
  output weight4_t          wts
);

  localparam int SQ_W   = 2 * T_LOG + 1;
  localparam int CUBE_W = 3 * T_LOG + 1;
  localparam int WIDE_W = CUBE_W + 5;

  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam wide_t TWO_S3 = wide_t'(1) <<< (3 * T_LOG + 1);
  localparam wide_t W_HALF = wide_t'(1) <<< (W_SHIFT - 1);

  logic [FRAC_W-1:0]        f_a_r;
  logic [FRAC_W-1:0]        f_b_r;
  logic [FRAC_W-1:0]        f_c_r;
  logic [2*FRAC_W-1:0]      sq;
  logic [SQ_W-1:0]          f2_b_r;
  logic [SQ_W-1:0]          f2_c_r;
  logic [SQ_W+FRAC_W-1:0]   cube;
  logic [CUBE_W-1:0]        f3_c_r;
  wide_t                    t1;
  wide_t                    t2;
  wide_t                    t3;
  wide_t                    t3x3;
  weight4_t                 w_nxt;
  weight4_t                 w_r;

  function automatic weight_t rnd_w(input wide_t v);
    wide_t b;
    b = (v + W_HALF) >>> W_SHIFT;
    rnd_w = weight_t'(b);
  endfunction

  assign sq   = f_a_r * f_a_r;
  assign cube = f2_b_r * f_b_r;

  // Clamp t to one, then square and cube it
  always_ff @(posedge clk) begin
    f_a_r  <= (frac > FRAC_W'(T_ONE)) ? FRAC_W'(T_ONE) : frac;
    f_b_r  <= f_a_r;
    f2_b_r <= sq[SQ_W-1:0];
    f_c_r  <= f_b_r;
    f2_c_r <= f2_b_r;
    f3_c_r <= cube[CUBE_W-1:0];
    w_r    <= w_nxt;
  end

  // Basis polynomials scaled by 2^49, rounded to Q30
  always_comb begin
    t1   = wide_t'(f_c_r);
    t2   = wide_t'(f2_c_r);
    t3   = wide_t'(f3_c_r);
    t3x3 = t3 + (t3 <<< 1);
    w_nxt[0] = rnd_w(-t3 + (t2 <<< (T_LOG + 1)) - (t1 <<< (2 * T_LOG)));
    w_nxt[1] = rnd_w(t3x3 - ((t2 <<< T_LOG) + (t2 <<< (T_LOG + 2))) + TWO_S3);
    w_nxt[2] = rnd_w(-t3x3 + (t2 <<< (T_LOG + 2)) + (t1 <<< (2 * T_LOG)));
    w_nxt[3] = rnd_w(t3 - (t2 <<< T_LOG));
  end

  assign wts = w_r;

endmodule

FILE: hdl/crpe_blend.sv
module crpe_blend
  import crpe_pkg::*;
(
  input  logic     clk,
  input  coord4_t  pts,
  input  weight4_t wts,
  output coord_t   res
);

  localparam int PROD_W = 2 * COORD_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int SH_W   = ACC_W - ACC_SHIFT;

  localparam logic signed [PROD_W+1:0] ACC_HALF =
    (PROD_W + 2)'(1) << (ACC_SHIFT - 1);

  logic signed [PROD_W-1:0] prod_r [4];
  logic signed [PROD_W:0]   s01_r;
  logic signed [PROD_W+1:0] s23_r;
  logic signed [ACC_W-1:0]  acc;
  logic [SH_W-1:0]          sh;
  logic [SH_W-COORD_W:0]    top_bits;
  coord_t                   res_nxt;
  coord_t                   res_r;

  // Weigh each point
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      prod_r[k] <= $signed(pts[k]) * $signed(wts[k]);
    end
  end

  // Add in pairs, fold in the rounding half
  always_ff @(posedge clk) begin
    s01_r <= prod_r[0] + prod_r[1];
    s23_r <= prod_r[2] + prod_r[3] + ACC_HALF;
  end

  // Final sum, drop fraction bits, saturate
  always_comb begin
    acc      = s01_r + s23_r;
    sh       = acc[ACC_W-1:ACC_SHIFT];
    top_bits = sh[SH_W-1:COORD_W-1];
    if ((&top_bits) || !(|top_bits)) begin
      res_nxt = sh[COORD_W-1:0];
    end else if (sh[SH_W-1]) begin
      res_nxt = {1'b1, {(COORD_W - 1){1'b0}}};
    end else begin
      res_nxt = {1'b0, {(COORD_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

FILE: hdl/crpe_checker.sv
`include "catmull_rom_point_eval_core_assert.svh"

module crpe_checker
  import crpe_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input in_item_t         in_item,
  input logic             out_valid,
  input out_item_t        out_item,
  input logic             cfg_we,
  input logic [CNT_W-1:0] cfg_wdata
);

  // Every evaluate transaction yields a result after the pipeline latency
  `CRPE_ASSERT_IMPL(a_eval_gives_result, start && !busy && (in_item.action == ACT_EVAL), ##PIPE_LAT out_valid, "evaluate transaction lost")

  // Every result traces back to an evaluate transaction
  `CRPE_ASSERT_IMPL(a_no_spurious_result, out_valid, $past(start && !busy && (in_item.action == ACT_EVAL), PIPE_LAT), "result without evaluate transaction")

  // An out-of-range result carries zero coordinates
  `CRPE_ASSERT_ALWAYS(a_range_zero, !(out_valid && !out_item.in_range) || ((out_item.out_x == '0) && (out_item.out_y == '0)), "out-of-range result not zero")

endmodule

bind catmull_rom_point_eval_core crpe_checker u_crpe_checker (.*);
